@@ hdl/chbd_pkg.sv @@
// ---------------------------------------------------------------------------
// chbd_pkg: shared types and constants for the chunked body decoder
// Size width, character codes, phase and error codes, and the classified
// item that travels from the front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package chbd_pkg;

    // Width of the chunk size accumulator and remaining-byte counter
    localparam int SIZE_BITS = 32;

    // Hex digit width and radix
    localparam int DIGIT_BITS = 4;
    localparam int HEX_RADIX  = 16;
    localparam int DEC_DIGITS = 10;

    // Character codes
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_LA   = 8'h61;  // 'a'
    localparam logic [7:0] CH_UA   = 8'h41;  // 'A'

    // Input operations
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Parser phase
    typedef enum logic [2:0] {
        PH_DIGITS  = 3'd0,
        PH_EXT     = 3'd1,
        PH_DATA    = 3'd2,
        PH_CRLF    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_EMPTY_SIZE = 3'd1,
        ERR_BAD_SIZE   = 3'd2,
        ERR_FRAMING    = 3'd3,
        ERR_AFTER_END  = 3'd4,
        ERR_INCOMPLETE = 3'd5
    } t_err;

    // Classified item handed from front to back
    typedef struct packed {
        logic                  is_eos;
        logic [7:0]            data_byte;
        logic                  is_cr;
        logic                  is_lf;
        logic                  is_semi;
        logic                  hex_ok;
        logic [DIGIT_BITS-1:0] hex_val;
    } t_cls_item;

    // Push side of the item queue
    typedef struct packed {
        logic      valid;
        t_cls_item item;
    } t_push;

    // Pop side of the item queue
    typedef struct packed {
        logic      valid;
        t_cls_item item;
    } t_pop;

endpackage

`default_nettype wire

@@ hdl/chbd_ifs.sv @@
// ---------------------------------------------------------------------------
// chbd_ifs: stream channels of the chunked body decoder
// Input channel carries a byte or end-of-stream event; output channel
// carries one result per input transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface chbd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface chbd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_complete;
    logic [2:0] error_code;

    modport source (output valid, output payload_valid, output payload_byte,
                    output body_complete, output error_code, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input body_complete, input error_code, output ready);
endinterface

`default_nettype wire

@@ hdl/chbd_front.sv @@
// ---------------------------------------------------------------------------
// chbd_front: input front end
// Accepts input transfers while the queue has room and classifies each
// byte (CR, LF, ';', hex digit value).
// ---------------------------------------------------------------------------
`default_nettype none

module chbd_front (
    chbd_in_if.sink          i_in,
    input  logic             i_full,
    output chbd_pkg::t_push  o_push
);

    logic [7:0] w_b;

    assign w_b       = i_in.data_byte;
    assign i_in.ready = !i_full;

    // Classify the byte
    always_comb begin
        o_push.valid          = i_in.valid && !i_full;
        o_push.item.is_eos    = (i_in.operation == chbd_pkg::OP_EOS);
        o_push.item.data_byte = w_b;
        o_push.item.is_cr     = (w_b == chbd_pkg::CH_CR);
        o_push.item.is_lf     = (w_b == chbd_pkg::CH_LF);
        o_push.item.is_semi   = (w_b == chbd_pkg::CH_SEMI);
        o_push.item.hex_ok    = 1'b1;
        o_push.item.hex_val   = '0;
        if (w_b inside {[8'h30:8'h39]}) begin
            o_push.item.hex_val = chbd_pkg::DIGIT_BITS'(w_b - chbd_pkg::CH_ZERO);
        end else if (w_b inside {[8'h61:8'h66]}) begin
            o_push.item.hex_val = chbd_pkg::DIGIT_BITS'(w_b - chbd_pkg::CH_LA
                                  + 8'(chbd_pkg::DEC_DIGITS));
        end else if (w_b inside {[8'h41:8'h46]}) begin
            o_push.item.hex_val = chbd_pkg::DIGIT_BITS'(w_b - chbd_pkg::CH_UA
                                  + 8'(chbd_pkg::DEC_DIGITS));
        end else begin
            o_push.item.hex_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/chbd_queue.sv @@
// ---------------------------------------------------------------------------
// chbd_queue: two-entry item queue
// Decouples the front end from the back end so either side can stall.
// ---------------------------------------------------------------------------
`default_nettype none

module chbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chbd_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_full,
    output chbd_pkg::t_pop   o_pop
);

    chbd_pkg::t_cls_item r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_pop.valid = (r_count != 2'd0);
    assign o_pop.item  = r_mem[r_rd_ptr];
    assign w_do_pop    = i_pop && o_pop.valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) r_wr_ptr <= !r_wr_ptr;
            if (w_do_pop)     r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push.valid) - 2'(w_do_pop);
        end
    end

endmodule

`default_nettype wire

@@ hdl/chbd_back.sv @@
// ---------------------------------------------------------------------------
// chbd_back: parser back end
// Runs the chunk framing state machine on one queued item per cycle while
// the output keeps up; each result waits in the output register until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module chbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chbd_pkg::t_pop   i_pop,
    output logic             o_pop,
    chbd_out_if.source       o_out
);

    localparam int SB = chbd_pkg::SIZE_BITS;
    localparam int DB = chbd_pkg::DIGIT_BITS;

    chbd_pkg::t_phase r_phase,  n_phase;
    logic [SB-1:0]    r_chunk,  n_chunk;
    logic             r_crp,    n_crp;
    logic             r_seen,   n_seen;
    logic             r_inval,  n_inval;
    logic             r_ffok,   n_ffok;
    logic             r_tnon,   n_tnon;
    chbd_pkg::t_err   r_err,    n_err;

    logic             r_out_valid;
    logic             r_pv;
    logic [7:0]       r_pbyte;
    logic             r_done;
    chbd_pkg::t_err   r_oerr;

    logic             n_pv;
    logic [7:0]       n_pbyte;
    logic             w_step;
    chbd_pkg::t_cls_item w_it;

    assign w_it   = i_pop.item;
    assign o_pop  = !r_out_valid || o_out.ready;
    assign w_step = i_pop.valid && o_pop;

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_pv;
    assign o_out.payload_byte  = r_pbyte;
    assign o_out.body_complete = r_done;
    assign o_out.error_code    = r_oerr;

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= chbd_pkg::PH_DIGITS;
            r_chunk <= '0;
            r_crp   <= 1'b0;
            r_seen  <= 1'b0;
            r_inval <= 1'b0;
            r_ffok  <= 1'b0;
            r_tnon  <= 1'b0;
            r_err   <= chbd_pkg::ERR_NONE;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_chunk <= n_chunk;
            r_crp   <= n_crp;
            r_seen  <= n_seen;
            r_inval <= n_inval;
            r_ffok  <= n_ffok;
            r_tnon  <= n_tnon;
            r_err   <= n_err;
        end
    end

    // Next state for one item
    always_comb begin
        n_phase = r_phase;
        n_chunk = r_chunk;
        n_crp   = r_crp;
        n_seen  = r_seen;
        n_inval = r_inval;
        n_ffok  = r_ffok;
        n_tnon  = r_tnon;
        n_err   = r_err;
        n_pv    = 1'b0;
        n_pbyte = '0;
        if (r_err == chbd_pkg::ERR_NONE) begin
            if (w_it.is_eos) begin
                if (r_phase != chbd_pkg::PH_DONE) n_err = chbd_pkg::ERR_INCOMPLETE;
            end else begin
                case (r_phase)
                    chbd_pkg::PH_DIGITS, chbd_pkg::PH_EXT: begin
                        if (r_crp && w_it.is_lf) begin
                            if (!r_seen) begin
                                n_err = chbd_pkg::ERR_EMPTY_SIZE;
                            end else if (r_inval) begin
                                n_err = chbd_pkg::ERR_BAD_SIZE;
                            end else if (r_chunk == '0) begin
                                n_crp   = 1'b0;
                                n_tnon  = 1'b0;
                                n_phase = chbd_pkg::PH_TRAILER;
                            end else begin
                                n_crp   = 1'b0;
                                n_phase = chbd_pkg::PH_DATA;
                            end
                        end else begin
                            // Held CR turned out to be a plain line character
                            if (r_crp && r_phase == chbd_pkg::PH_DIGITS) begin
                                n_seen  = 1'b1;
                                n_inval = 1'b1;
                            end
                            n_crp = w_it.is_cr;
                            if (!w_it.is_cr && r_phase == chbd_pkg::PH_DIGITS) begin
                                if (w_it.is_semi) begin
                                    n_phase = chbd_pkg::PH_EXT;
                                end else begin
                                    n_seen = 1'b1;
                                    if (!n_inval) begin
                                        if (!w_it.hex_ok || r_chunk[SB-1 -: DB] != '0) begin
                                            n_inval = 1'b1;
                                        end else begin
                                            n_chunk = {r_chunk[SB-DB-1:0], w_it.hex_val};
                                        end
                                    end
                                end
                            end
                        end
                    end
                    chbd_pkg::PH_DATA: begin
                        n_pv    = 1'b1;
                        n_pbyte = w_it.data_byte;
                        n_chunk = r_chunk - SB'(1);
                        if (r_chunk == SB'(1)) begin
                            n_ffok  = 1'b0;
                            n_crp   = 1'b0;
                            n_phase = chbd_pkg::PH_CRLF;
                        end
                    end
                    chbd_pkg::PH_CRLF: begin
                        if (!r_crp) begin
                            n_ffok = w_it.is_cr;
                            n_crp  = 1'b1;
                        end else if (r_ffok && w_it.is_lf) begin
                            n_phase = chbd_pkg::PH_DIGITS;
                            n_chunk = '0;
                            n_crp   = 1'b0;
                            n_seen  = 1'b0;
                            n_inval = 1'b0;
                        end else begin
                            n_err = chbd_pkg::ERR_FRAMING;
                        end
                    end
                    chbd_pkg::PH_TRAILER: begin
                        if (r_crp && w_it.is_lf) begin
                            n_crp = 1'b0;
                            if (!r_tnon) n_phase = chbd_pkg::PH_DONE;
                            n_tnon = 1'b0;
                        end else begin
                            n_crp = w_it.is_cr;
                            if (r_crp || !w_it.is_cr) n_tnon = 1'b1;
                        end
                    end
                    chbd_pkg::PH_DONE: begin
                        n_err = chbd_pkg::ERR_AFTER_END;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (n_err != chbd_pkg::ERR_NONE) begin
            n_pv    = 1'b0;
            n_pbyte = '0;
        end
    end

    // Output register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= i_pop.valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_pv    <= n_pv;
            r_pbyte <= n_pbyte;
            r_done  <= (n_phase == chbd_pkg::PH_DONE);
            r_oerr  <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
// ---------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder
// Parses chunk-size lines, passes chunk data, checks framing and trailers.
// ---------------------------------------------------------------------------
// Every input transfer (a body byte or an end-of-stream event) yields exactly
// one result transfer carrying payload_valid/payload_byte, body_complete and
// a sticky error_code. The block takes one item per clock cycle when the
// output side keeps up. Each item waits in the two-entry item queue, and its
// result is held in the output register until it is taken. While the output
// is stalled, two items wait in the queue behind the held result before the
// input stops accepting. The rate is set by the back end's parser update,
// which applies one hex digit shift-and-add or one data-count decrement per
// item.
// ---------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chbd_in_if.sink     i_in,
    chbd_out_if.source  o_out
);

    chbd_pkg::t_push w_push;
    chbd_pkg::t_pop  w_pop_data;
    logic            w_full;
    logic            w_pop;

    // Front end: accept and classify
    chbd_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    // Item queue between front and back
    chbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_pop   (w_pop_data)
    );

    // Back end: parser and result register
    chbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pop   (w_pop_data),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ dv/tb_http_chunked_body_decoder.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_http_chunked_body_decoder: regression for the chunked body decoder
// Feeds one long chunked body byte by byte (size lines with extensions,
// leading zeros, mixed-case digits, trailers) and closes the stream with one
// randomly chosen ending: clean completion or one of the error cases. Every
// input transfer is decoded by a cycle-free model of the parser; each result
// transfer is compared field by field against the oldest predicted result.
// ---------------------------------------------------------------------------

module tb_http_chunked_body_decoder;

    localparam int CLK_HALF     = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1620;
    localparam int DRAIN_CYCLES = 8;
    localparam int NOISE_ITEMS  = 20;

    // One input transfer
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } body_item_t;

    // One result transfer
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       body_complete;
        logic [2:0] error_code;
    } decoded_t;

    // How the stream is closed after the random body
    typedef enum int {
        END_COMPLETE,
        END_EOS_TRAILER,
        END_EOS_DATA,
        END_EMPTY_SIZE,
        END_BAD_DIGIT,
        END_OVERFLOW,
        END_FRAMING,
        END_MAX_SIZE_EOS
    } ending_t;

    // -----------------------------------------------------------------------
    // Parser model plus queue of decoded results still owed by the block
    // -----------------------------------------------------------------------
    class body_decode_tracker;
        chbd_pkg::t_phase               phase;
        logic [chbd_pkg::SIZE_BITS-1:0] remaining;
        bit                             cr_pending;
        bit                             size_seen;
        bit                             size_bad;
        bit                             frame_cr_ok;
        bit                             trailer_nonempty;
        chbd_pkg::t_err                 sticky;
        decoded_t                       awaited[$];
        int                             mismatches;
        int                             payload_seen;

        function new();
            begin_size_line();
            frame_cr_ok      = 1'b0;
            trailer_nonempty = 1'b0;
            sticky           = chbd_pkg::ERR_NONE;
            mismatches       = 0;
            payload_seen     = 0;
        endfunction

        function void begin_size_line();
            phase      = chbd_pkg::PH_DIGITS;
            remaining  = '0;
            cr_pending = 1'b0;
            size_seen  = 1'b0;
            size_bad   = 1'b0;
        endfunction

        function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (c >= chbd_pkg::CH_ZERO && c < chbd_pkg::CH_ZERO + chbd_pkg::DEC_DIGITS) begin
                v = 4'(c - chbd_pkg::CH_ZERO);
                return 1'b1;
            end
            if (c >= chbd_pkg::CH_LA &&
                c < chbd_pkg::CH_LA + chbd_pkg::HEX_RADIX - chbd_pkg::DEC_DIGITS) begin
                v = 4'(c - chbd_pkg::CH_LA + chbd_pkg::DEC_DIGITS);
                return 1'b1;
            end
            if (c >= chbd_pkg::CH_UA &&
                c < chbd_pkg::CH_UA + chbd_pkg::HEX_RADIX - chbd_pkg::DEC_DIGITS) begin
                v = 4'(c - chbd_pkg::CH_UA + chbd_pkg::DEC_DIGITS);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // One character of the size part; extension characters are dropped
        function void size_char(input logic [7:0] c);
            logic [3:0] v;
            bit         ok;
            if (phase != chbd_pkg::PH_DIGITS) return;
            if (c == chbd_pkg::CH_SEMI) begin
                phase = chbd_pkg::PH_EXT;
                return;
            end
            size_seen = 1'b1;
            if (size_bad) return;
            ok = hex_digit(c, v);
            if (!ok || remaining[chbd_pkg::SIZE_BITS-1 -: chbd_pkg::DIGIT_BITS] != '0) begin
                size_bad = 1'b1;
                return;
            end
            remaining = {remaining[chbd_pkg::SIZE_BITS-chbd_pkg::DIGIT_BITS-1:0], v};
        endfunction

        function decoded_t decode_step(input logic op, input logic [7:0] b);
            decoded_t r;
            r = '0;
            if (sticky == chbd_pkg::ERR_NONE) begin
                if (op == chbd_pkg::OP_EOS) begin
                    if (phase != chbd_pkg::PH_DONE) sticky = chbd_pkg::ERR_INCOMPLETE;
                end else begin
                    case (phase)
                        chbd_pkg::PH_DIGITS, chbd_pkg::PH_EXT: begin
                            if (cr_pending && b == chbd_pkg::CH_LF) begin
                                if (!size_seen) sticky = chbd_pkg::ERR_EMPTY_SIZE;
                                else if (size_bad) sticky = chbd_pkg::ERR_BAD_SIZE;
                                else if (remaining == '0) begin
                                    cr_pending       = 1'b0;
                                    trailer_nonempty = 1'b0;
                                    phase            = chbd_pkg::PH_TRAILER;
                                end else begin
                                    cr_pending = 1'b0;
                                    phase      = chbd_pkg::PH_DATA;
                                end
                            end else begin
                                // a CR not followed by LF is an ordinary character
                                if (cr_pending) size_char(chbd_pkg::CH_CR);
                                cr_pending = (b == chbd_pkg::CH_CR);
                                if (b != chbd_pkg::CH_CR) size_char(b);
                            end
                        end
                        chbd_pkg::PH_DATA: begin
                            r.payload_valid = 1'b1;
                            r.payload_byte  = b;
                            remaining       = remaining - 1;
                            if (remaining == '0) begin
                                frame_cr_ok = 1'b0;
                                cr_pending  = 1'b0;
                                phase       = chbd_pkg::PH_CRLF;
                            end
                        end
                        chbd_pkg::PH_CRLF: begin
                            // error only shows on the second byte after the data
                            if (!cr_pending) begin
                                frame_cr_ok = (b == chbd_pkg::CH_CR);
                                cr_pending  = 1'b1;
                            end else if (frame_cr_ok && b == chbd_pkg::CH_LF) begin
                                begin_size_line();
                            end else begin
                                sticky = chbd_pkg::ERR_FRAMING;
                            end
                        end
                        chbd_pkg::PH_TRAILER: begin
                            if (cr_pending && b == chbd_pkg::CH_LF) begin
                                cr_pending = 1'b0;
                                if (!trailer_nonempty) phase = chbd_pkg::PH_DONE;
                                trailer_nonempty = 1'b0;
                            end else begin
                                if (cr_pending) trailer_nonempty = 1'b1;
                                cr_pending = (b == chbd_pkg::CH_CR);
                                if (b != chbd_pkg::CH_CR) trailer_nonempty = 1'b1;
                            end
                        end
                        chbd_pkg::PH_DONE: sticky = chbd_pkg::ERR_AFTER_END;
                        default: ;
                    endcase
                end
            end
            if (sticky != chbd_pkg::ERR_NONE) begin
                r.payload_valid = 1'b0;
                r.payload_byte  = '0;
            end
            r.body_complete = (phase == chbd_pkg::PH_DONE);
            r.error_code    = sticky;
            return r;
        endfunction

        function void note_input(input logic op, input logic [7:0] b);
            awaited.push_back(decode_step(op, b));
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input decoded_t got);
            decoded_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %0b/%0h/%0b/%0d",
                         $time, got.payload_valid, got.payload_byte, got.body_complete,
                         got.error_code);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (want.payload_valid) payload_seen++;
            compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("body_complete", 8'(want.body_complete), 8'(got.body_complete));
            compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    chbd_in_if  in_ch ();
    chbd_out_if out_ch ();

    http_chunked_body_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    body_decode_tracker tracker = new();

    body_item_t stim_items[$];
    ending_t    ending;
    int         directed_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_requested;
    int         input_stalls;
    int         cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.awaited.size());
        $display("http_chunked_body_decoder regression: fail");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stream builders
    // -----------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        stim_items.push_back(body_item_t'{chbd_pkg::OP_DATA, b});
    endfunction

    function automatic void put_eos();
        stim_items.push_back(body_item_t'{chbd_pkg::OP_EOS, 8'($urandom)});
    endfunction

    function automatic void put_crlf();
        put_byte(chbd_pkg::CH_CR);
        put_byte(chbd_pkg::CH_LF);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < chbd_pkg::DEC_DIGITS) return 8'(chbd_pkg::CH_ZERO + v);
        return 8'((upper ? chbd_pkg::CH_UA : chbd_pkg::CH_LA) + v - chbd_pkg::DEC_DIGITS);
    endfunction

    // Free line text, CR and LF favored, never a CR LF pair inside
    function automatic void put_line_text(input int n);
        logic [7:0] b;
        logic [7:0] prev;
        prev = 8'h00;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0:       b = chbd_pkg::CH_CR;
                1:       b = chbd_pkg::CH_LF;
                default: b = 8'($urandom);
            endcase
            if (prev == chbd_pkg::CH_CR && b == chbd_pkg::CH_LF) b = chbd_pkg::CH_SEMI;
            put_byte(b);
            prev = b;
        end
    endfunction

    function automatic void put_size_line(input logic [chbd_pkg::SIZE_BITS-1:0] size,
                                          input int zeros, input bit ext);
        int                             n;
        logic [chbd_pkg::SIZE_BITS-1:0] s;
        n = 0;
        s = size;
        do begin
            n++;
            s = s >> chbd_pkg::DIGIT_BITS;
        end while (s != '0);
        repeat (zeros) put_byte(chbd_pkg::CH_ZERO);
        for (int i = n - 1; i >= 0; i--)
            put_byte(hex_char(size[i*chbd_pkg::DIGIT_BITS +: chbd_pkg::DIGIT_BITS],
                              1'($urandom_range(1))));
        if (ext) begin
            put_byte(chbd_pkg::CH_SEMI);
            put_line_text($urandom_range(0, 6));
        end
        put_crlf();
    endfunction

    function automatic void put_chunk(input int unsigned len);
        put_size_line(len, ($urandom_range(5) == 0) ? $urandom_range(1, 4) : 0,
                      $urandom_range(2) == 0);
        repeat (len) put_byte(8'($urandom));
        put_crlf();
    endfunction

    // -----------------------------------------------------------------------
    // Sender: random idle cycles, then hold the item until it is taken
    // -----------------------------------------------------------------------
    task automatic send_item(input body_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.data_byte <= it.data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_input(it.op, it.data);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requested) begin
                hold_requested = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check on every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result(decoded_t'{out_ch.payload_valid, out_ch.payload_byte,
                                            out_ch.body_complete, out_ch.error_code});
        if (i_rst_n && in_ch.valid && !in_ch.ready) input_stalls++;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] bad_chars [8];
        int         pick;
        int         len;
        int         seg;
        int         prev_seg;
        int         span;

        // characters just outside the hex ranges, plus the byte extremes
        bad_chars = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = chbd_pkg::OP_DATA;
        in_ch.data_byte = 8'h00;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requested  = 1'b0;
        input_stalls    = 0;

        // directed: single byte chunk, extension with lone CR, leading zeros
        put_byte("1"); put_crlf(); put_byte(8'hFF); put_crlf();
        put_byte("2"); put_byte(chbd_pkg::CH_SEMI); put_byte(chbd_pkg::CH_CR);
        put_byte("x"); put_crlf();
        put_byte(8'h00); put_byte(chbd_pkg::CH_CR); put_crlf();
        put_byte(chbd_pkg::CH_ZERO); put_byte(chbd_pkg::CH_ZERO);
        put_byte(chbd_pkg::CH_ZERO); put_byte("1");
        put_byte(chbd_pkg::CH_SEMI); put_byte(chbd_pkg::CH_LF); put_crlf();
        put_byte(chbd_pkg::CH_LF); put_crlf();
        directed_count = stim_items.size();

        // random body: mostly short chunks, a few long ones
        while (stim_items.size() < directed_count + RANDOM_ITEMS)
            put_chunk(($urandom_range(9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 20));

        // close the stream one way or another
        pick   = $urandom_range(11);
        ending = (pick < 5) ? END_COMPLETE : ending_t'(pick - 4);
        case (ending)
            END_COMPLETE: begin
                put_size_line('0, $urandom_range(2), 1'($urandom_range(1)));
                repeat ($urandom_range(3)) begin
                    put_line_text($urandom_range(1, 10));
                    put_crlf();
                end
                put_crlf();
                repeat ($urandom_range(1, 3)) put_eos();
            end
            END_EOS_TRAILER: begin
                put_size_line('0, 0, 1'b0);
                put_line_text($urandom_range(1, 8));
                put_crlf();
                put_line_text($urandom_range(0, 4));
                put_eos();
            end
            END_EOS_DATA: begin
                len = $urandom_range(2, 20);
                put_size_line(len, 0, 1'b0);
                repeat ($urandom_range(0, len - 1)) put_byte(8'($urandom));
                put_eos();
            end
            END_EMPTY_SIZE: begin
                if ($urandom_range(1)) begin
                    put_byte(chbd_pkg::CH_SEMI);
                    put_line_text($urandom_range(0, 5));
                end
                put_crlf();
            end
            END_BAD_DIGIT: begin
                repeat ($urandom_range(0, 3))
                    put_byte(hex_char(4'($urandom), 1'($urandom_range(1))));
                case ($urandom_range(2))
                    0: put_byte(bad_chars[$urandom_range(7)]);
                    1: begin
                        put_byte(chbd_pkg::CH_CR);
                        put_byte(hex_char(4'($urandom), 1'b0));
                    end
                    default: put_byte(chbd_pkg::CH_LF);
                endcase
                repeat ($urandom_range(0, 2)) put_byte(hex_char(4'($urandom), 1'b1));
                put_crlf();
            end
            END_OVERFLOW: begin
                put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
                repeat (chbd_pkg::SIZE_BITS / chbd_pkg::DIGIT_BITS)
                    put_byte(hex_char(4'($urandom), 1'($urandom_range(1))));
                put_crlf();
            end
            END_FRAMING: begin
                len = $urandom_range(1, 12);
                put_size_line(len, 0, 1'b0);
                repeat (len) put_byte(8'($urandom));
                if ($urandom_range(1)) begin
                    b1 = 8'($urandom);
                    if (b1 == chbd_pkg::CH_CR) b1 = chbd_pkg::CH_LF;
                    put_byte(b1);
                    put_byte(8'($urandom));
                end else begin
                    b2 = 8'($urandom);
                    if (b2 == chbd_pkg::CH_LF) b2 = chbd_pkg::CH_CR;
                    put_byte(chbd_pkg::CH_CR);
                    put_byte(b2);
                end
            end
            default: begin
                put_size_line({chbd_pkg::SIZE_BITS{1'b1}}, 0, 1'b0);
                repeat ($urandom_range(1, 30)) put_byte(8'($urandom));
                put_eos();
            end
        endcase

        // trailing noise: the held error or completion must not move
        repeat (NOISE_ITEMS) begin
            if ($urandom_range(3) == 0) put_eos();
            else put_byte(8'($urandom));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        span     = stim_items.size() - directed_count;
        prev_seg = 0;
        for (int k = 0; k < stim_items.size(); k++) begin
            if (k >= directed_count) begin
                seg = (k - directed_count) * 4 / span;
                case (seg)
                    0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
                    default: begin send_idle_pct = 27; recv_stall_pct = 27; end
                endcase
                // back up the output while the input keeps offering
                if (k == directed_count) hold_requested = 1'b1;
                // drain everything before the last segment
                if (seg == 3 && prev_seg != 3) begin
                    in_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (tracker.awaited.size() != 0);
                end
                prev_seg = seg;
            end
            send_item(stim_items[k]);
        end
        in_ch.valid <= 1'b0;

        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers (%0d directed), %0d payload bytes, %0d input stall cycles",
                 stim_items.size(), directed_count, tracker.payload_seen, input_stalls);
        $display("stream ending %s, final error code %0d, body complete %0b",
                 ending.name(), tracker.sticky, tracker.phase == chbd_pkg::PH_DONE);
        if (tracker.mismatches == 0) begin
            $display("http_chunked_body_decoder regression: pass");
        end else begin
            $display("http_chunked_body_decoder regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/chbd_pkg.sv
hdl/chbd_ifs.sv
hdl/chbd_front.sv
hdl/chbd_queue.sv
hdl/chbd_back.sv
hdl/http_chunked_body_decoder.sv
dv/tb_http_chunked_body_decoder.sv
